>>> sv/gdda_pkg.sv
// ----------------------------------------------------------------------------
// gdda_pkg
// Shared types, codes and constant tables for the Gregorian date arithmetic
// block: stride tables for the year decomposition and month lookups.
// ----------------------------------------------------------------------------
`default_nettype none

package gdda_pkg;

    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 14;
    localparam int ADD_W   = 22;
    localparam int DIFF_W  = 22;
    localparam int STAT_W  = 2;
    localparam int DN_W    = 24;
    localparam int YR_W    = 17;
    localparam int STEP_W  = 4;
    localparam int NUM_STEPS = 16;
    localparam int MSTART_W  = 9;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);
    localparam logic [MON_W-1:0]  JAN       = 4'd1;
    localparam logic [MON_W-1:0]  FEB       = 4'd2;
    localparam logic [MON_W-1:0]  DEC       = 4'd12;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_FIRST_BAD  = 2'd1,
        ST_SECOND_BAD = 2'd2,
        ST_RANGE      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD1,
        S_DEC1,
        S_MON1,
        S_LOAD2,
        S_DEC2,
        S_MON2,
        S_JUDGE,
        S_DIFFA,
        S_DIFFB,
        S_ADDN,
        S_LOADN,
        S_REV,
        S_YEAR,
        S_MONTH,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_STEP,
        OP_MONSUM,
        OP_JUDGE,
        OP_DIFFA,
        OP_DIFFB,
        OP_ADDN,
        OP_LOADN,
        OP_YEAR,
        OP_MSTEP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [STEP_W-1:0] step;
        logic              sel2;
        logic              rev;
    } ctrl_t;

    typedef struct packed {
        logic ok1;
        logic ok2;
        logic mode;
        logic fail;
        logic mdone;
    } dp_stat_t;

    typedef struct packed {
        logic              req_type;
        logic [DAY_W-1:0]  first_day;
        logic [MON_W-1:0]  first_month;
        logic [YEAR_W-1:0] first_year;
        logic [DAY_W-1:0]  second_day;
        logic [MON_W-1:0]  second_month;
        logic [YEAR_W-1:0] second_year;
        logic [ADD_W-1:0]  days_to_add;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [DIFF_W-1:0] day_difference;
        logic [DAY_W-1:0]  result_day;
        logic [MON_W-1:0]  result_month;
        logic [YEAR_W-1:0] result_year;
    } result_t;

    // Year stride of each restoring step: binary multiples of 400, 100, 4 and 1 year groups.
    function automatic logic [YR_W-1:0] year_stride(input logic [STEP_W-1:0] step);
        logic [YR_W-1:0] v;
        unique case (step)
            4'd0:  v = 17'd25600;
            4'd1:  v = 17'd12800;
            4'd2:  v = 17'd6400;
            4'd3:  v = 17'd3200;
            4'd4:  v = 17'd1600;
            4'd5:  v = 17'd800;
            4'd6:  v = 17'd400;
            4'd7:  v = 17'd200;
            4'd8:  v = 17'd100;
            4'd9:  v = 17'd64;
            4'd10: v = 17'd32;
            4'd11: v = 17'd16;
            4'd12: v = 17'd8;
            4'd13: v = 17'd4;
            4'd14: v = 17'd2;
            4'd15: v = 17'd1;
        endcase
        return v;
    endfunction

    // Day count that matches each year stride.
    function automatic logic [DN_W-1:0] day_stride(input logic [STEP_W-1:0] step);
        logic [DN_W-1:0] v;
        unique case (step)
            4'd0:  v = 24'd9350208;
            4'd1:  v = 24'd4675104;
            4'd2:  v = 24'd2337552;
            4'd3:  v = 24'd1168776;
            4'd4:  v = 24'd584388;
            4'd5:  v = 24'd292194;
            4'd6:  v = 24'd146097;
            4'd7:  v = 24'd73048;
            4'd8:  v = 24'd36524;
            4'd9:  v = 24'd23376;
            4'd10: v = 24'd11688;
            4'd11: v = 24'd5844;
            4'd12: v = 24'd2922;
            4'd13: v = 24'd1461;
            4'd14: v = 24'd730;
            4'd15: v = 24'd365;
        endcase
        return v;
    endfunction

    // Leap year from the quotient bits of the decomposition of year - 1.
    function automatic logic leap_of(input logic [NUM_STEPS-1:0] taken);
        logic [1:0] q100;
        logic [4:0] q4;
        logic [1:0] q1;
        q100 = {taken[7], taken[8]};
        q4   = {taken[9], taken[10], taken[11], taken[12], taken[13]};
        q1   = {taken[14], taken[15]};
        return (q1 == 2'd3) && ((q4 != 5'd24) || (q100 == 2'd3));
    endfunction

    function automatic logic [MSTART_W-1:0] month_start(input logic [MON_W-1:0] m);
        logic [MSTART_W-1:0] v;
        unique case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] v;
        unique case (m)
            4'd1:    v = 5'd31;
            4'd2:    v = leap ? 5'd29 : 5'd28;
            4'd3:    v = 5'd31;
            4'd4:    v = 5'd30;
            4'd5:    v = 5'd31;
            4'd6:    v = 5'd30;
            4'd7:    v = 5'd31;
            4'd8:    v = 5'd31;
            4'd9:    v = 5'd30;
            4'd10:   v = 5'd31;
            4'd11:   v = 5'd30;
            4'd12:   v = 5'd31;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> sv/gdda_alu.sv
// ----------------------------------------------------------------------------
// gdda_alu
// Shared arithmetic unit: one subtract-and-compare and one accumulate add.
// ----------------------------------------------------------------------------
`default_nettype none

module gdda_alu
(
    input  wire logic [gdda_pkg::DN_W-1:0] sub_a,
    input  wire logic [gdda_pkg::DN_W-1:0] sub_b,
    input  wire logic [gdda_pkg::DN_W-1:0] add_a,
    input  wire logic [gdda_pkg::DN_W-1:0] add_b,
    output logic      [gdda_pkg::DN_W-1:0] sub_res,
    output logic                           borrow,
    output logic      [gdda_pkg::DN_W-1:0] add_res
);

    assign {borrow, sub_res} = {1'b0, sub_a} - {1'b0, sub_b};
    assign add_res = add_a + add_b;

endmodule

`default_nettype wire

>>> sv/gdda_dp.sv
// ----------------------------------------------------------------------------
// gdda_dp
// Datapath: request registers, remainder and accumulator, quotient bits,
// month walk and result assembly around the shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

module gdda_dp #(
    parameter int MAX_YEAR = 9999
)
(
    input  wire logic                clk,
    input  wire gdda_pkg::ctrl_t     ctl,
    input  wire gdda_pkg::req_t      req,
    output gdda_pkg::dp_stat_t       stat,
    output gdda_pkg::result_t        res
);

    localparam int DN_W = gdda_pkg::DN_W;
    localparam int YR_W = gdda_pkg::YR_W;

    gdda_pkg::req_t                      req_reg,    req_next;
    logic [DN_W-1:0]                     rem_reg,    rem_next;
    logic [DN_W-1:0]                     acc_reg,    acc_next;
    logic [DN_W-1:0]                     dn1_reg,    dn1_next;
    logic [gdda_pkg::NUM_STEPS-1:0]      taken_reg,  taken_next;
    logic [YR_W-1:0]                     year_reg,   year_next;
    logic [gdda_pkg::MON_W-1:0]          month_reg,  month_next;
    logic                                ok1_reg,    ok1_next;
    logic                                ok2_reg,    ok2_next;
    logic                                neg_reg,    neg_next;
    gdda_pkg::status_t                   status_reg, status_next;

    logic [DN_W-1:0]                     sub_a, sub_b, add_a, add_b;
    logic [DN_W-1:0]                     sub_res, add_res;
    logic                                borrow;

    logic [gdda_pkg::DAY_W-1:0]          d_sel;
    logic [gdda_pkg::MON_W-1:0]          m_sel;
    logic [gdda_pkg::YEAR_W-1:0]         y_sel;
    logic                                leap;
    logic [gdda_pkg::DAY_W-1:0]          dim_sel;
    logic [gdda_pkg::DAY_W-1:0]          dim_cur;
    logic                                date_ok;
    logic                                leap_adj;
    logic [DN_W-1:0]                     mon_off;
    logic                                mdone;
    logic                                res_ok;

    assign d_sel = ctl.sel2 ? req_reg.second_day   : req_reg.first_day;
    assign m_sel = ctl.sel2 ? req_reg.second_month : req_reg.first_month;
    assign y_sel = ctl.sel2 ? req_reg.second_year  : req_reg.first_year;

    assign leap    = gdda_pkg::leap_of(taken_reg);
    assign dim_sel = gdda_pkg::month_days(m_sel, leap);
    assign dim_cur = gdda_pkg::month_days(month_reg, leap);

    assign date_ok = (m_sel != '0) && (m_sel <= gdda_pkg::DEC)
                  && (y_sel != '0) && (YR_W'(y_sel) <= YR_W'(MAX_YEAR))
                  && (d_sel != '0) && (d_sel <= dim_sel);

    assign leap_adj = leap && (m_sel > gdda_pkg::FEB);
    assign mon_off  = DN_W'(gdda_pkg::month_start(m_sel)) + DN_W'(leap_adj) + DN_W'(d_sel);

    // Operand select for the shared unit
    always_comb
    begin
        sub_a = rem_reg;
        sub_b = '0;
        add_a = acc_reg;
        add_b = '0;
        unique case (ctl.op)
            gdda_pkg::OP_LOAD:
            begin
                sub_a = DN_W'(y_sel);
                sub_b = DN_W'(1);
            end
            gdda_pkg::OP_STEP:
            begin
                if (ctl.rev)
                begin
                    sub_b = gdda_pkg::day_stride(ctl.step);
                    add_b = DN_W'(gdda_pkg::year_stride(ctl.step));
                end
                else
                begin
                    sub_b = DN_W'(gdda_pkg::year_stride(ctl.step));
                    add_b = gdda_pkg::day_stride(ctl.step);
                end
            end
            gdda_pkg::OP_MONSUM:
            begin
                add_b = mon_off;
            end
            gdda_pkg::OP_DIFFA:
            begin
                sub_a = dn1_reg;
                sub_b = acc_reg;
            end
            gdda_pkg::OP_DIFFB:
            begin
                sub_a = acc_reg;
                sub_b = dn1_reg;
            end
            gdda_pkg::OP_ADDN:
            begin
                add_a = dn1_reg;
                add_b = DN_W'(req_reg.days_to_add);
            end
            gdda_pkg::OP_LOADN:
            begin
                sub_a = acc_reg;
                sub_b = DN_W'(1);
            end
            gdda_pkg::OP_YEAR:
            begin
                add_b = DN_W'(1);
            end
            gdda_pkg::OP_MSTEP:
            begin
                sub_b = DN_W'(dim_cur);
            end
            default:
            begin
                sub_b = '0;
            end
        endcase
    end

    gdda_alu u_alu
    (
        .sub_a   (sub_a),
        .sub_b   (sub_b),
        .add_a   (add_a),
        .add_b   (add_b),
        .sub_res (sub_res),
        .borrow  (borrow),
        .add_res (add_res)
    );

    assign mdone = (month_reg >= gdda_pkg::DEC) || borrow;

    // Register updates
    always_comb
    begin
        req_next    = req_reg;
        rem_next    = rem_reg;
        acc_next    = acc_reg;
        dn1_next    = dn1_reg;
        taken_next  = taken_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        ok1_next    = ok1_reg;
        ok2_next    = ok2_reg;
        neg_next    = neg_reg;
        status_next = status_reg;
        unique case (ctl.op)
            gdda_pkg::OP_CAPTURE:
            begin
                req_next    = req;
                status_next = gdda_pkg::ST_OK;
            end
            gdda_pkg::OP_LOAD,
            gdda_pkg::OP_LOADN:
            begin
                rem_next   = sub_res;
                acc_next   = '0;
                taken_next = '0;
            end
            gdda_pkg::OP_STEP:
            begin
                if (!borrow)
                begin
                    rem_next             = sub_res;
                    acc_next             = add_res;
                    taken_next[ctl.step] = 1'b1;
                end
            end
            gdda_pkg::OP_MONSUM:
            begin
                if (ctl.sel2)
                begin
                    acc_next = add_res;
                    ok2_next = date_ok;
                end
                else
                begin
                    dn1_next = add_res;
                    ok1_next = date_ok;
                end
            end
            gdda_pkg::OP_JUDGE:
            begin
                priority if (!ok1_reg)
                    status_next = gdda_pkg::ST_FIRST_BAD;
                else if (!ok2_reg)
                    status_next = gdda_pkg::ST_SECOND_BAD;
                else
                    status_next = gdda_pkg::ST_OK;
            end
            gdda_pkg::OP_DIFFA:
            begin
                rem_next = sub_res;
                neg_next = borrow;
            end
            gdda_pkg::OP_DIFFB:
            begin
                if (neg_reg)
                    rem_next = sub_res;
            end
            gdda_pkg::OP_ADDN:
            begin
                acc_next = add_res;
            end
            gdda_pkg::OP_YEAR:
            begin
                year_next  = add_res[YR_W-1:0];
                month_next = gdda_pkg::JAN;
                if (add_res > DN_W'(MAX_YEAR))
                    status_next = gdda_pkg::ST_RANGE;
            end
            gdda_pkg::OP_MSTEP:
            begin
                if (!mdone)
                begin
                    rem_next   = sub_res;
                    month_next = month_reg + 1'b1;
                end
            end
            default:
            begin
                req_next = req_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rem_reg    <= rem_next;
        acc_reg    <= acc_next;
        dn1_reg    <= dn1_next;
        taken_reg  <= taken_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        ok1_reg    <= ok1_next;
        ok2_reg    <= ok2_next;
        neg_reg    <= neg_next;
        status_reg <= status_next;
    end

    assign stat.ok1   = ok1_reg;
    assign stat.ok2   = ok2_reg;
    assign stat.mode  = req_reg.req_type;
    assign stat.fail  = (status_reg != gdda_pkg::ST_OK);
    assign stat.mdone = mdone;

    assign res_ok = (status_reg == gdda_pkg::ST_OK);

    always_comb
    begin
        res                = '0;
        res.status         = status_reg;
        if (res_ok && !req_reg.req_type)
            res.day_difference = rem_reg[gdda_pkg::DIFF_W-1:0];
        if (res_ok && req_reg.req_type)
        begin
            res.result_day   = rem_reg[gdda_pkg::DAY_W-1:0] + 1'b1;
            res.result_month = month_reg;
            res.result_year  = year_reg[gdda_pkg::YEAR_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> sv/gdda_ctrl.sv
// ----------------------------------------------------------------------------
// gdda_ctrl
// Sequencer: walks both dates through the stride division, then, if both are
// valid, the difference or add-and-convert-back path, one operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gdda_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 out_free,
    input  wire gdda_pkg::dp_stat_t   stat,
    output gdda_pkg::ctrl_t           ctl,
    output logic                      in_ready,
    output logic                      done_fire
);

    gdda_pkg::state_t                 state_reg, state_next;
    logic [gdda_pkg::STEP_W-1:0]      step_reg,  step_next;
    logic                             last_step;

    assign last_step = (step_reg == gdda_pkg::LAST_STEP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gdda_pkg::S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = '0;
        unique case (state_reg)
            gdda_pkg::S_IDLE:
                if (in_valid)
                    state_next = gdda_pkg::S_LOAD1;
            gdda_pkg::S_LOAD1:
                state_next = gdda_pkg::S_DEC1;
            gdda_pkg::S_DEC1:
            begin
                step_next = step_reg + 1'b1;
                if (last_step)
                    state_next = gdda_pkg::S_MON1;
            end
            gdda_pkg::S_MON1:
                state_next = gdda_pkg::S_LOAD2;
            gdda_pkg::S_LOAD2:
                state_next = gdda_pkg::S_DEC2;
            gdda_pkg::S_DEC2:
            begin
                step_next = step_reg + 1'b1;
                if (last_step)
                    state_next = gdda_pkg::S_MON2;
            end
            gdda_pkg::S_MON2:
                state_next = gdda_pkg::S_JUDGE;
            gdda_pkg::S_JUDGE:
            begin
                priority if (!stat.ok1 || !stat.ok2)
                    state_next = gdda_pkg::S_DONE;
                else if (stat.mode)
                    state_next = gdda_pkg::S_ADDN;
                else
                    state_next = gdda_pkg::S_DIFFA;
            end
            gdda_pkg::S_DIFFA:
                state_next = gdda_pkg::S_DIFFB;
            gdda_pkg::S_DIFFB:
                state_next = gdda_pkg::S_DONE;
            gdda_pkg::S_ADDN:
                state_next = gdda_pkg::S_LOADN;
            gdda_pkg::S_LOADN:
                state_next = gdda_pkg::S_REV;
            gdda_pkg::S_REV:
            begin
                step_next = step_reg + 1'b1;
                if (last_step)
                    state_next = gdda_pkg::S_YEAR;
            end
            gdda_pkg::S_YEAR:
                state_next = gdda_pkg::S_MONTH;
            gdda_pkg::S_MONTH:
                if (stat.fail || stat.mdone)
                    state_next = gdda_pkg::S_DONE;
            gdda_pkg::S_DONE:
                if (out_free)
                    state_next = gdda_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl.op    = gdda_pkg::OP_NONE;
        ctl.step  = step_reg;
        ctl.sel2  = 1'b0;
        ctl.rev   = 1'b0;
        in_ready  = 1'b0;
        done_fire = 1'b0;
        unique case (state_reg)
            gdda_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    ctl.op = gdda_pkg::OP_CAPTURE;
            end
            gdda_pkg::S_LOAD1:
                ctl.op = gdda_pkg::OP_LOAD;
            gdda_pkg::S_DEC1:
                ctl.op = gdda_pkg::OP_STEP;
            gdda_pkg::S_MON1:
                ctl.op = gdda_pkg::OP_MONSUM;
            gdda_pkg::S_LOAD2:
            begin
                ctl.op   = gdda_pkg::OP_LOAD;
                ctl.sel2 = 1'b1;
            end
            gdda_pkg::S_DEC2:
                ctl.op = gdda_pkg::OP_STEP;
            gdda_pkg::S_MON2:
            begin
                ctl.op   = gdda_pkg::OP_MONSUM;
                ctl.sel2 = 1'b1;
            end
            gdda_pkg::S_JUDGE:
                ctl.op = gdda_pkg::OP_JUDGE;
            gdda_pkg::S_DIFFA:
                ctl.op = gdda_pkg::OP_DIFFA;
            gdda_pkg::S_DIFFB:
                ctl.op = gdda_pkg::OP_DIFFB;
            gdda_pkg::S_ADDN:
                ctl.op = gdda_pkg::OP_ADDN;
            gdda_pkg::S_LOADN:
                ctl.op = gdda_pkg::OP_LOADN;
            gdda_pkg::S_REV:
            begin
                ctl.op  = gdda_pkg::OP_STEP;
                ctl.rev = 1'b1;
            end
            gdda_pkg::S_YEAR:
                ctl.op = gdda_pkg::OP_YEAR;
            gdda_pkg::S_MONTH:
                ctl.op = gdda_pkg::OP_MSTEP;
            gdda_pkg::S_DONE:
                done_fire = out_free;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/gregorian_date_day_arithmetic_top.sv
// ----------------------------------------------------------------------------
// gregorian_date_day_arithmetic_top
// Date arithmetic on proleptic Gregorian day numbers: days between two dates,
// or a date plus a day count converted back to day, month and year.
//
//   channel   dir  tdata                               tuser
//   s_*       in   request: two dates, day count      req_type
//   m_*       out  difference, result day/month/year  status
//
// The shared subtract/accumulate unit runs sixteen restoring stride steps per
// date and again for the back conversion, then up to eleven month steps.
// rst_n clears the sequencer and the output valid; datapath and output data registers are not reset.
// A finished result waits in the output register; the next request is taken
// while it waits, and the sequencer holds at its end until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_day_arithmetic_top #(
    parameter int MAX_YEAR = 9999
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // first_day, first_month, first_year, second_day, second_month,
    // second_year, days_to_add, zero pad
    input  wire logic [71:0] s_tdata,
    // req_type
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // day_difference, result_day, result_month, result_year, zero pad
    output logic [47:0]      m_tdata,
    // status
    output logic [1:0]       m_tuser
);

    gdda_pkg::req_t       req;
    gdda_pkg::ctrl_t      ctl;
    gdda_pkg::dp_stat_t   stat;
    gdda_pkg::result_t    res;
    gdda_pkg::result_t    out_reg;
    logic                 m_tvalid_reg;
    logic                 out_free;
    logic                 done_fire;

    assign req.req_type     = s_tuser[0];
    assign req.first_day    = s_tdata[4:0];
    assign req.first_month  = s_tdata[8:5];
    assign req.first_year   = s_tdata[22:9];
    assign req.second_day   = s_tdata[27:23];
    assign req.second_month = s_tdata[31:28];
    assign req.second_year  = s_tdata[45:32];
    assign req.days_to_add  = s_tdata[67:46];

    assign out_free = !m_tvalid_reg || m_tready;

    gdda_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_free  (out_free),
        .stat      (stat),
        .ctl       (ctl),
        .in_ready  (s_tready),
        .done_fire (done_fire)
    );

    gdda_dp #(
        .MAX_YEAR (MAX_YEAR)
    ) u_dp
    (
        .clk  (clk),
        .ctl  (ctl),
        .req  (req),
        .stat (stat),
        .res  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (done_fire)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
            out_reg <= res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {3'b000, out_reg.result_year, out_reg.result_month,
                       out_reg.result_day, out_reg.day_difference};

endmodule

`default_nettype wire
